[design/lsrc_pkg.sv]
// ----------------------------------------------------------------------------
// lsrc_pkg: shared types, constants and helpers for the level-set cell update
// Beat formats, configuration defaults and the per-axis upwind selection.
// ----------------------------------------------------------------------------
package lsrc_pkg;

    localparam logic [31:0] Q16_ONE        = 32'd65536;
    localparam logic [31:0] RST_INV_CELL   = 32'd65536;
    localparam logic [31:0] RST_PSEUDO     = 32'd3277;
    localparam logic [31:0] RST_TOLERANCE  = 32'd66;
    localparam logic [1:0]  RST_NUM_DIMS   = 2'd2;
    localparam int          SQRT_STAGES    = 16;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INV_CELL_X      = 3'd0;
    localparam logic [2:0] CFG_INV_CELL_Y      = 3'd1;
    localparam logic [2:0] CFG_INV_CELL_Z      = 3'd2;
    localparam logic [2:0] CFG_PSEUDO_STEP     = 3'd3;
    localparam logic [2:0] CFG_CHANGE_TOL      = 3'd4;
    localparam logic [2:0] CFG_NUM_DIMS        = 3'd5;

    typedef struct packed {
        logic signed [31:0] phi_center;
        logic signed [31:0] phi_west;
        logic signed [31:0] phi_east;
        logic signed [31:0] phi_south;
        logic signed [31:0] phi_north;
        logic signed [31:0] phi_below;
        logic signed [31:0] phi_above;
        logic               sweep_last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] phi_updated;
        logic               cell_converged;
        logic               sweep_done;
        logic               sweep_converged;
    } t_out_item;

    typedef struct packed {
        logic [31:0] inv_cell_x;
        logic [31:0] inv_cell_y;
        logic [31:0] inv_cell_z;
        logic [31:0] pseudo_step;
        logic [31:0] change_tolerance;
        logic [1:0]  num_dims;
    } t_cfg;

    // Per-cell values that ride along with the gradient computation.
    typedef struct packed {
        logic signed [31:0] c;
        logic               pos;
        logic               last;
    } t_side;

    // Upwind one-sided difference magnitude of one axis (fits 32 bits).
    function automatic logic [31:0] upwind_mag(input logic signed [31:0] c,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi,
                                               input logic               pos);
        logic signed [32:0] dm;
        logic signed [32:0] dp;
        logic [32:0]        am;
        logic [32:0]        ap;
        logic [32:0]        mp;
        logic [32:0]        mm;
        dm = 33'(c) - 33'(lo);
        dp = 33'(hi) - 33'(c);
        am = dm[32] ? 33'(-dm) : 33'(dm);
        ap = dp[32] ? 33'(-dp) : 33'(dp);
        mp = '0;
        mm = '0;
        if (pos ? (!dm[32] && dm != '0) : dm[32]) mp = am;
        if (pos ? dp[32] : (!dp[32] && dp != '0)) mm = ap;
        return (mp > mm) ? mp[31:0] : mm[31:0];
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

[design/lsrc_grad.sv]
// ----------------------------------------------------------------------------
// lsrc_grad: scaled upwind terms and their saturated sum of squares
// Four stages: scale by the reciprocal cell size, square, and two adds.
// ----------------------------------------------------------------------------
module lsrc_grad import lsrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0][31:0] i_mag,
    input  t_side            i_side,
    input  t_cfg             i_cfg,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [63:0]      o_sum,
    output t_side            o_side
);

    logic             r_va, r_vb, r_vc, r_vd;
    logic [2:0][63:0] r_prod;
    logic [2:0][63:0] r_sq;
    logic [63:0]      r_s01;
    logic [63:0]      r_sq2;
    logic [63:0]      r_sum;
    t_side            r_sa, r_sb, r_sc, r_sd;
    logic             w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;
    logic [2:0][63:0] n_sq;
    logic [31:0]      w_inv [3];

    assign w_rdy_d = !r_vd || i_ready;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    assign w_inv[0] = i_cfg.inv_cell_x;
    assign w_inv[1] = i_cfg.inv_cell_y;
    assign w_inv[2] = i_cfg.inv_cell_z;

    // A scaled term above 32 bits saturates its square.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_prod[a][63:48] != '0) begin
                n_sq[a] = {64{1'b1}};
            end else begin
                n_sq[a] = 64'(r_prod[a][47:16]) * 64'(r_prod[a][47:16]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
            if (w_rdy_d) r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= 64'(i_mag[a]) * 64'(w_inv[a]);
            end
            r_sa <= i_side;
        end
        if (w_rdy_b) begin
            r_sq <= n_sq;
            r_sb <= r_sa;
        end
        if (w_rdy_c) begin
            r_s01 <= sat_add64(r_sq[0], r_sq[1]);
            r_sq2 <= r_sq[2];
            r_sc  <= r_sb;
        end
        if (w_rdy_d) begin
            r_sum <= sat_add64(r_s01, r_sq2);
            r_sd  <= r_sc;
        end
    end

    assign o_valid = r_vd;
    assign o_sum   = r_sum;
    assign o_side  = r_sd;

endmodule

[design/lsrc_sqrt.sv]
// ----------------------------------------------------------------------------
// lsrc_sqrt: pipelined integer square root of a 64-bit value
// Digit-by-digit restoring method, two result bits per stage.
// ----------------------------------------------------------------------------
module lsrc_sqrt import lsrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_radicand,
    input  t_side       i_side,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_root,
    output t_side       o_side
);

    logic        r_v    [SQRT_STAGES];
    logic [34:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];
    logic [63:0] r_x    [SQRT_STAGES];
    t_side       r_side [SQRT_STAGES];

    logic        w_v    [SQRT_STAGES+1];
    logic        w_rdy  [SQRT_STAGES+1];
    logic [34:0] w_rem  [SQRT_STAGES+1];
    logic [31:0] w_root [SQRT_STAGES+1];
    logic [63:0] w_x    [SQRT_STAGES+1];
    t_side       w_side [SQRT_STAGES+1];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = i_radicand;
    assign w_side[0] = i_side;
    assign w_rdy[SQRT_STAGES] = i_ready;
    assign o_ready   = w_rdy[0];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [34:0] n_rem;
        logic [31:0] n_root;
        logic [63:0] n_x;
        logic [34:0] w_trial;

        // Bring down two radicand bits, then try the next root bit, twice.
        always_comb begin
            n_rem   = w_rem[k];
            n_root  = w_root[k];
            n_x     = w_x[k];
            w_trial = '0;
            for (int s = 0; s < 2; s++) begin
                n_rem   = {n_rem[32:0], n_x[63:62]};
                n_x     = {n_x[61:0], 2'b00};
                w_trial = {1'b0, n_root, 2'b01};
                if (n_rem >= w_trial) begin
                    n_rem  = n_rem - w_trial;
                    n_root = {n_root[30:0], 1'b1};
                end else begin
                    n_root = {n_root[30:0], 1'b0};
                end
            end
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_x[k]    <= n_x;
                r_side[k] <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v[k];
        assign w_rem[k+1]  = r_rem[k];
        assign w_root[k+1] = r_root[k];
        assign w_x[k+1]    = r_x[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_valid = w_v[SQRT_STAGES];
    assign o_root  = w_root[SQRT_STAGES];
    assign o_side  = w_side[SQRT_STAGES];

endmodule

[design/lsrc_upd.sv]
// ----------------------------------------------------------------------------
// lsrc_upd: pseudo-time update, saturation and convergence tracking
// Three stages; the last is the output register holding the sweep verdict.
// ----------------------------------------------------------------------------
module lsrc_upd import lsrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_grad,
    input  t_side       i_side,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    logic               r_v1, r_v2, r_v3;
    logic [31:0]        r_abs;
    logic               r_add1, r_add2;
    logic [47:0]        r_mag;
    t_side              r_s1, r_s2;
    t_out_item          r_out;
    logic               r_all;
    logic               w_rdy1, w_rdy2, w_rdy3;
    logic signed [32:0] w_e;
    logic [32:0]        w_abs;
    logic               w_add;
    logic [63:0]        w_prod;
    logic signed [49:0] w_upd;
    logic signed [31:0] w_sat;
    logic               w_conv;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Error of the gradient magnitude against one, and its direction.
    assign w_e   = $signed({1'b0, i_grad}) - $signed({1'b0, Q16_ONE});
    assign w_abs = w_e[32] ? 33'(-w_e) : 33'(w_e);
    assign w_add = i_side.pos ? w_e[32] : (!w_e[32] && w_e != '0);

    assign w_prod = 64'(r_abs) * 64'(i_cfg.pseudo_step);

    always_comb begin
        if (r_add2) begin
            w_upd = 50'(r_s2.c) + $signed({2'b00, r_mag});
        end else begin
            w_upd = 50'(r_s2.c) - $signed({2'b00, r_mag});
        end
        if (w_upd[49:31] == '0 || w_upd[49:31] == '1) begin
            w_sat = w_upd[31:0];
        end else if (w_upd[49]) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = 32'sh7FFF_FFFF;
        end
    end

    assign w_conv = r_mag <= 48'(i_cfg.change_tolerance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_all <= 1'b1;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            // The sweep flag moves only when a beat enters the output register.
            if (w_rdy3 && r_v2) begin
                r_all <= r_s2.last ? 1'b1 : (r_all && w_conv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_abs  <= w_abs[31:0];
            r_add1 <= w_add;
            r_s1   <= i_side;
        end
        if (w_rdy2) begin
            r_mag  <= w_prod[63:16];
            r_add2 <= r_add1;
            r_s2   <= r_s1;
        end
        if (w_rdy3) begin
            r_out.phi_updated     <= w_sat;
            r_out.cell_converged  <= w_conv;
            r_out.sweep_done      <= r_s2.last;
            r_out.sweep_converged <= r_s2.last && r_all && w_conv;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_out;

endmodule

[design/level_set_reinit_cell_update.sv]
// ----------------------------------------------------------------------------
// level_set_reinit_cell_update: one reinitialization step per grid cell
// Upwind gradient, square root and Q16.16 pseudo-time update of phi.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one cell per beat: the center value, its six
//   axis neighbors and a flag marking the last cell of a sweep. The output
//   channel returns one beat per cell with the updated value, a per-cell
//   convergence flag and, on the last cell, the AND of all flags of the sweep.
//   Both channels use valid/ready. Configuration is written through a plain
//   write port (enable, index, data), by the user only while the block is
//   idle, which the block itself does not enforce; unknown indexes are ignored.
//   From input beat to output beat a cell passes one input stage, four
//   for the scaled squares and their sum, sixteen for the square root
//   (two root bits per stage) and three for the update and output register.
//   Throughput is one cell per cycle when not stalled. Every stage has its
//   own valid bit and holds when the stage after it is full and stalled,
//   so a stalled receiver backs the pipeline up stage by stage while empty
//   stages still fill. Reset empties the pipeline, loads the default
//   configuration and sets the sweep flag to converged.
// ----------------------------------------------------------------------------
module level_set_reinit_cell_update import lsrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    t_cfg             r_cfg;
    logic             r_v0;
    logic [2:0][31:0] r_mag;
    t_side            r_side;
    logic             w_rdy0;
    logic             w_grad_ready;
    logic [2:0][31:0] n_mag;
    t_side            n_side;
    logic             w_sum_valid;
    logic             w_sum_ready;
    logic [63:0]      w_sum;
    t_side            w_sum_side;
    logic             w_root_valid;
    logic             w_root_ready;
    logic [31:0]      w_root;
    t_side            w_root_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_cell_x       <= RST_INV_CELL;
            r_cfg.inv_cell_y       <= RST_INV_CELL;
            r_cfg.inv_cell_z       <= RST_INV_CELL;
            r_cfg.pseudo_step      <= RST_PSEUDO;
            r_cfg.change_tolerance <= RST_TOLERANCE;
            r_cfg.num_dims         <= RST_NUM_DIMS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_CELL_X:  r_cfg.inv_cell_x       <= i_cfg_wdata;
                CFG_INV_CELL_Y:  r_cfg.inv_cell_y       <= i_cfg_wdata;
                CFG_INV_CELL_Z:  r_cfg.inv_cell_z       <= i_cfg_wdata;
                CFG_PSEUDO_STEP: r_cfg.pseudo_step      <= i_cfg_wdata;
                CFG_CHANGE_TOL:  r_cfg.change_tolerance <= i_cfg_wdata;
                CFG_NUM_DIMS:    r_cfg.num_dims         <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // Zero counts as negative; axes beyond the configured count give zero.
    always_comb begin
        n_side.c    = i_in_data.phi_center;
        n_side.pos  = !i_in_data.phi_center[31] && i_in_data.phi_center != '0;
        n_side.last = i_in_data.sweep_last;
        n_mag[0] = (r_cfg.num_dims != 2'd0)
                 ? upwind_mag(i_in_data.phi_center, i_in_data.phi_west,
                              i_in_data.phi_east, n_side.pos) : '0;
        n_mag[1] = r_cfg.num_dims[1]
                 ? upwind_mag(i_in_data.phi_center, i_in_data.phi_south,
                              i_in_data.phi_north, n_side.pos) : '0;
        n_mag[2] = (r_cfg.num_dims == 2'd3)
                 ? upwind_mag(i_in_data.phi_center, i_in_data.phi_below,
                              i_in_data.phi_above, n_side.pos) : '0;
    end

    assign w_rdy0     = !r_v0 || w_grad_ready;
    assign o_in_ready = w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_rdy0) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_mag  <= n_mag;
            r_side <= n_side;
        end
    end

    lsrc_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .o_ready (w_grad_ready),
        .i_mag   (r_mag),
        .i_side  (r_side),
        .i_cfg   (r_cfg),
        .o_valid (w_sum_valid),
        .i_ready (w_sum_ready),
        .o_sum   (w_sum),
        .o_side  (w_sum_side)
    );

    lsrc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_sum_valid),
        .o_ready    (w_sum_ready),
        .i_radicand (w_sum),
        .i_side     (w_sum_side),
        .o_valid    (w_root_valid),
        .i_ready    (w_root_ready),
        .o_root     (w_root),
        .o_side     (w_root_side)
    );

    lsrc_upd u_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_root_valid),
        .o_ready (w_root_ready),
        .i_grad  (w_root),
        .i_side  (w_root_side),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

[tb/level_set_reinit_cell_update_test.sv]
// ----------------------------------------------------------------------------
// level_set_reinit_cell_update_test: self-checking bench for the cell update
// Drives cells through the valid/ready input, predicts each updated value and
// the per-cell and per-sweep convergence flags, and compares every output beat.
// ----------------------------------------------------------------------------
module level_set_reinit_cell_update_test;
    import lsrc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;

    level_set_reinit_cell_update dut (.*);

    always #5 i_clk = ~i_clk;

    // Configuration and sweep flag as the bench believes them to be.
    logic [31:0] inv_x, inv_y, inv_z, tau, tol;
    logic [1:0]  dims;
    logic        sweep_ok;

    t_out_item   expected_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] op, res, b;
        op = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > op) b = b >> 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op = op - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Squared, scaled upwind term of one axis in Q32.32, saturated.
    function automatic logic [63:0] axis_square(input longint c, input longint lo,
                                                input longint hi, input bit pos,
                                                input logic [31:0] inv);
        longint      dm, dp;
        logic [63:0] mp, mm, m, v;
        dm = c - lo;
        dp = hi - c;
        mp = 0;
        mm = 0;
        if (pos ? (dm > 0) : (dm < 0)) mp = (dm < 0) ? -dm : dm;
        if (pos ? (dp < 0) : (dp > 0)) mm = (dp < 0) ? -dp : dp;
        m = (mp > mm) ? mp : mm;
        v = (m * {32'd0, inv}) >> 16;
        if (v > 64'hFFFF_FFFF) return '1;
        return v * v;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic t_out_item predict_cell(input t_in_item x);
        t_out_item   r;
        longint      c, e, upd;
        bit          pos, add, conv;
        logic [63:0] sum, grad, mag, ae;
        c = longint'(x.phi_center);
        pos = c > 0;
        sum = 0;
        if (dims >= 1) sum = add_sat(sum, axis_square(c, x.phi_west, x.phi_east, pos, inv_x));
        if (dims >= 2) sum = add_sat(sum, axis_square(c, x.phi_south, x.phi_north, pos, inv_y));
        if (dims >= 3) sum = add_sat(sum, axis_square(c, x.phi_below, x.phi_above, pos, inv_z));
        grad = root64(sum);
        e = longint'(grad) - 65536;
        ae = (e < 0) ? -e : e;
        mag = (ae * {32'd0, tau}) >> 16;
        add = pos ? (e < 0) : (e > 0);
        upd = add ? c + longint'(mag) : c - longint'(mag);
        if (upd > 64'sd2147483647) upd = 64'sd2147483647;
        if (upd < -64'sd2147483648) upd = -64'sd2147483648;
        conv = mag <= {32'd0, tol};
        sweep_ok = sweep_ok & conv;
        r.phi_updated = upd[31:0];
        r.cell_converged = conv;
        r.sweep_done = x.sweep_last;
        r.sweep_converged = x.sweep_last & sweep_ok;
        if (x.sweep_last) sweep_ok = 1'b1;
        return r;
    endfunction

    // Valid stays high between back-to-back beats; drain lowers it at the end.
    task automatic send_cell(input t_in_item x);
        while (($urandom % 100) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.push_back(predict_cell(x));
        @(negedge i_clk);
    endtask

    // Output checker: one beat per edge with valid and ready both high.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", o_out_data);
            end else begin
                t_out_item want;
                want = expected_q.pop_front();
                if (want !== o_out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, o_out_data);
                end
            end
        end
    end

    always @(negedge i_clk) i_out_ready <= ($urandom % 100) >= recv_stall_pct;

    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_INV_CELL_X:  inv_x = v;
            CFG_INV_CELL_Y:  inv_y = v;
            CFG_INV_CELL_Z:  inv_z = v;
            CFG_PSEUDO_STEP: tau = v;
            CFG_CHANGE_TOL:  tol = v;
            CFG_NUM_DIMS:    dims = v[1:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_phi();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            default: return $urandom;
        endcase
    endfunction

    // Smooth neighbors near a signed-distance field so cells can converge.
    function automatic t_in_item smooth_cell(input bit last);
        t_in_item x;
        int       c;
        c = int'($urandom_range(0, 2000000)) - 1000000;
        x.phi_center = c;
        x.phi_west = c - 65536 + int'($urandom_range(0, 40)) - 20;
        x.phi_east = c + 65536 + int'($urandom_range(0, 40)) - 20;
        x.phi_south = c + int'($urandom_range(0, 40)) - 20;
        x.phi_north = c + int'($urandom_range(0, 40)) - 20;
        x.phi_below = c + int'($urandom_range(0, 40)) - 20;
        x.phi_above = c + int'($urandom_range(0, 40)) - 20;
        x.sweep_last = last;
        return x;
    endfunction

    function automatic t_in_item noisy_cell();
        t_in_item x;
        x.phi_center = rand_phi();
        x.phi_west = rand_phi();
        x.phi_east = rand_phi();
        x.phi_south = rand_phi();
        x.phi_north = rand_phi();
        x.phi_below = rand_phi();
        x.phi_above = rand_phi();
        x.sweep_last = ($urandom % 8) == 0;
        return x;
    endfunction

    task automatic test_directed;
        t_in_item x;
        logic [31:0] ext[4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
        write_reg(CFG_NUM_DIMS, 32'd3);
        foreach (ext[i]) begin
            foreach (ext[j]) begin
                x = '{ext[i], ext[j], ext[3 - j], ext[j], ext[i], ext[3 - i], ext[j],
                      (j == 3)};
                send_cell(x);
            end
        end
        // Flat field gives zero gradient; exact unit slope converges.
        send_cell('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
        send_cell('{32'd65536, 32'd0, 32'd131072, 32'd65536, 32'd65536,
                    32'd65536, 32'd65536, 1'b1});
        send_cell(smooth_cell(1'b0));
        send_cell(smooth_cell(1'b1));
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(CFG_INV_CELL_X, 32'hFFFF_FFFF);
        write_reg(CFG_INV_CELL_Y, 32'd0);
        write_reg(CFG_INV_CELL_Z, 32'd131072);
        write_reg(CFG_PSEUDO_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_CHANGE_TOL, 32'hFFFF_FFFF);
        write_reg(CFG_NUM_DIMS, 32'd0);
        for (int n = 0; n < 40; n++) send_cell(noisy_cell());
        drain();
        write_reg(CFG_NUM_DIMS, 32'd3);
        write_reg(CFG_PSEUDO_STEP, 32'd0);
        write_reg(CFG_CHANGE_TOL, 32'd0);
        for (int n = 0; n < 40; n++) send_cell(noisy_cell());
        drain();
        // An unused index must leave every register alone.
        write_reg(3'd6, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'h1234_5678);
    endtask

    task automatic test_random(input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_reg(CFG_INV_CELL_X, ($urandom % 2) ? 32'd65536 : $urandom_range(0, 262144));
        write_reg(CFG_INV_CELL_Y, ($urandom % 2) ? 32'd65536 : $urandom);
        write_reg(CFG_INV_CELL_Z, $urandom_range(0, 262144));
        write_reg(CFG_PSEUDO_STEP, ($urandom % 2) ? 32'd3277 : $urandom_range(0, 131072));
        write_reg(CFG_CHANGE_TOL, ($urandom % 2) ? 32'd66 : $urandom_range(0, 2000));
        write_reg(CFG_NUM_DIMS, $urandom_range(1, 3));
        for (int n = 0; n < 370; n++) begin
            if (($urandom % 4) == 0) send_cell(noisy_cell());
            else send_cell(smooth_cell(($urandom % 6) == 0));
        end
        drain();
    endtask

    initial begin
        inv_x = RST_INV_CELL;
        inv_y = RST_INV_CELL;
        inv_z = RST_INV_CELL;
        tau = RST_PSEUDO;
        tol = RST_TOLERANCE;
        dims = RST_NUM_DIMS;
        sweep_ok = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(0, 0);
        test_random(61, 0);
        test_random(0, 61);
        test_random(15, 15);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
design/lsrc_pkg.sv
design/lsrc_grad.sv
design/lsrc_sqrt.sv
design/lsrc_upd.sv
design/level_set_reinit_cell_update.sv
tb/level_set_reinit_cell_update_test.sv
